### rtl/segint_pkg.sv
`timescale 1ns / 1ps

package segint_pkg;

    // Width of every coordinate field on the channels
    localparam int FIELD_W = 32;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

### rtl/segint_if.sv
`timescale 1ns / 1ps

// Request channel: two segments
interface seg_in_if
    import segint_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] a_start_x;
    logic [FIELD_W-1:0] a_start_y;
    logic [FIELD_W-1:0] a_end_x;
    logic [FIELD_W-1:0] a_end_y;
    logic [FIELD_W-1:0] b_start_x;
    logic [FIELD_W-1:0] b_start_y;
    logic [FIELD_W-1:0] b_end_x;
    logic [FIELD_W-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

// Result channel: hit flag and point
interface seg_out_if
    import segint_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIELD_W-1:0] point_x;
    logic [FIELD_W-1:0] point_y;

    modport source (
        output valid, hit, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, hit, point_x, point_y,
        output ready
    );
endinterface

### rtl/segment_intersection.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle, sustained, while results are taken.
// Path from request to result: 2 front stages, queue, FRAC_BITS + 1 divider
// stages, multiply, output.
// The divider pipeline, one quotient bit per stage, sets the latency.
// Reset (rst_n low, asynchronous) empties every stage and the queue.
module segment_intersection
    import segint_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    seg_in_if.sink     seg_in,
    seg_out_if.source  seg_out
);

    localparam int D       = COORD_WIDTH + 1;
    localparam int PW      = 2 * COORD_WIDTH + 3;
    localparam int ENTRY_W = 1 + 2 * (PW - 1) + 4 * COORD_WIDTH + 2 * D;

    logic               push, pop, fifo_valid;
    logic [ENTRY_W-1:0] push_data, fifo_data;
    logic [FIFO_AW:0]   fifo_level;

    segint_front #(
        .CW      (COORD_WIDTH),
        .ENTRY_W (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_in     (seg_in),
        .fifo_level (fifo_level),
        .push       (push),
        .push_data  (push_data)
    );

    segint_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_valid (fifo_valid),
        .pop_data  (fifo_data),
        .level     (fifo_level)
    );

    segint_back #(
        .CW      (COORD_WIDTH),
        .FB      (FRAC_BITS),
        .ENTRY_W (ENTRY_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_valid (fifo_valid),
        .fifo_data  (fifo_data),
        .pop        (pop),
        .seg_out    (seg_out)
    );

endmodule

### rtl/segint_fifo.sv
`timescale 1ns / 1ps

module segint_fifo
    import segint_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data,
    output logic [FIFO_AW:0] level
);

    logic [WIDTH-1:0]   entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, wr_next;
    logic [FIFO_AW-1:0] rd_reg, rd_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               do_pop;

    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = entry_reg[rd_reg];
    assign level     = cnt_reg;
    assign do_pop    = pop && pop_valid;

    // Pointer and count update
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

endmodule

### rtl/segint_front.sv
`timescale 1ns / 1ps

module segint_front
    import segint_pkg::*;
#(
    parameter int CW      = 32,
    parameter int ENTRY_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    seg_in_if.sink             seg_in,
    input  logic [FIFO_AW:0]   fifo_level,
    output logic               push,
    output logic [ENTRY_W-1:0] push_data
);

    localparam int D  = CW + 1;
    localparam int PW = 2 * CW + 3;

    logic                 take;
    logic                 v1_reg, v2_reg;

    // stage 1: differences
    logic signed [D-1:0]  s1x_reg, s1y_reg, s2x_reg, s2y_reg, dx_reg, dy_reg;
    logic signed [CW-1:0] ax_reg, ay_reg, aex_reg, aey_reg;
    logic signed [CW-1:0] ax_in, ay_in, aex_in, aey_in, bx_in, by_in, bex_in, bey_in;

    // stage 2: products
    logic signed [2*D-1:0] pd0_reg, pd1_reg, ps0_reg, ps1_reg, pt0_reg, pt1_reg;
    logic signed [D-1:0]   s1x2_reg, s1y2_reg;
    logic signed [CW-1:0]  ax2_reg, ay2_reg, aex2_reg, aey2_reg;

    // classify
    logic signed [PW-1:0] den, ns, nt, den_f, ns_f, nt_f;
    logic                 flip, hit;

    // Credit: never accept more than the queue can still absorb
    assign seg_in.ready = (32'(fifo_level) + 32'(v1_reg) + 32'(v2_reg)) < FIFO_DEPTH;
    assign take         = seg_in.valid && seg_in.ready;

    assign ax_in  = $signed(seg_in.a_start_x[CW-1:0]);
    assign ay_in  = $signed(seg_in.a_start_y[CW-1:0]);
    assign aex_in = $signed(seg_in.a_end_x[CW-1:0]);
    assign aey_in = $signed(seg_in.a_end_y[CW-1:0]);
    assign bx_in  = $signed(seg_in.b_start_x[CW-1:0]);
    assign by_in  = $signed(seg_in.b_start_y[CW-1:0]);
    assign bex_in = $signed(seg_in.b_end_x[CW-1:0]);
    assign bey_in = $signed(seg_in.b_end_y[CW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
        end
    end

    // Direction vectors and start offset
    always_ff @(posedge clk)
    begin
        s1x_reg <= D'(aex_in) - D'(ax_in);
        s1y_reg <= D'(aey_in) - D'(ay_in);
        s2x_reg <= D'(bex_in) - D'(bx_in);
        s2y_reg <= D'(bey_in) - D'(by_in);
        dx_reg  <= D'(ax_in) - D'(bx_in);
        dy_reg  <= D'(ay_in) - D'(by_in);
        ax_reg  <= ax_in;
        ay_reg  <= ay_in;
        aex_reg <= aex_in;
        aey_reg <= aey_in;
    end

    // Cross products
    always_ff @(posedge clk)
    begin
        pd0_reg  <= s1x_reg * s2y_reg;
        pd1_reg  <= s2x_reg * s1y_reg;
        ps0_reg  <= s1x_reg * dy_reg;
        ps1_reg  <= s1y_reg * dx_reg;
        pt0_reg  <= s2x_reg * dy_reg;
        pt1_reg  <= s2y_reg * dx_reg;
        s1x2_reg <= s1x_reg;
        s1y2_reg <= s1y_reg;
        ax2_reg  <= ax_reg;
        ay2_reg  <= ay_reg;
        aex2_reg <= aex_reg;
        aey2_reg <= aey_reg;
    end

    // Denominator sign fix and range test of s and t
    always_comb
    begin
        den   = PW'(pd0_reg) - PW'(pd1_reg);
        ns    = PW'(ps0_reg) - PW'(ps1_reg);
        nt    = PW'(pt0_reg) - PW'(pt1_reg);
        flip  = den[PW-1];
        den_f = flip ? -den : den;
        ns_f  = flip ? -ns : ns;
        nt_f  = flip ? -nt : nt;
        hit   = (den_f != '0) && !ns_f[PW-1] && !nt_f[PW-1]
             && (ns_f[PW-2:0] <= den_f[PW-2:0]) && (nt_f[PW-2:0] <= den_f[PW-2:0]);
    end

    assign push      = v2_reg;
    assign push_data = {hit, den_f[PW-2:0], nt_f[PW-2:0], ax2_reg, ay2_reg,
                        aex2_reg, aey2_reg, s1x2_reg, s1y2_reg};

endmodule

### rtl/segint_back.sv
`timescale 1ns / 1ps

module segint_back
    import segint_pkg::*;
#(
    parameter int CW      = 32,
    parameter int FB      = 16,
    parameter int ENTRY_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fifo_valid,
    input  logic [ENTRY_W-1:0] fifo_data,
    output logic               pop,
    seg_out_if.source          seg_out
);

    localparam int D  = CW + 1;
    localparam int PW = 2 * CW + 3;
    localparam int NS = FB + 1;
    localparam int MW = FB + 1 + D;

    logic adv;

    // queue entry fields
    logic                 e_hit;
    logic [PW-2:0]        e_den, e_nt;
    logic signed [CW-1:0] e_ax, e_ay, e_aex, e_aey;
    logic signed [D-1:0]  e_s1x, e_s1y;

    // divider stages, one quotient bit each
    logic                 dv_reg  [NS];
    logic                 dh_reg  [NS];
    logic [PW-2:0]        dd_reg  [NS];
    logic [PW-2:0]        dr_reg  [NS];
    logic [FB:0]          dq_reg  [NS];
    logic signed [CW-1:0] dax_reg [NS];
    logic signed [CW-1:0] day_reg [NS];
    logic signed [CW-1:0] dex_reg [NS];
    logic signed [CW-1:0] dey_reg [NS];
    logic signed [D-1:0]  dsx_reg [NS];
    logic signed [D-1:0]  dsy_reg [NS];

    // multiply stage
    logic                 mv_reg, mh_reg, mnx_reg, mny_reg;
    logic [MW-1:0]        mx_reg, my_reg;
    logic signed [CW-1:0] max_reg, may_reg, mex_reg, mey_reg;
    logic [D-1:0]         absx, absy;
    logic signed [D-1:0]  lsx, lsy;

    // output stage
    logic                 ov_reg, oh_reg;
    logic [FIELD_W-1:0]   ox_reg, oy_reg;
    logic [D-1:0]         offx, offy;
    logic signed [D:0]    sox, soy, px, py;

    assign {e_hit, e_den, e_nt, e_ax, e_ay, e_aex, e_aey, e_s1x, e_s1y} = fifo_data;

    // Whole back pipeline moves when the output register can take a result
    assign adv = !ov_reg || seg_out.ready;
    assign pop = adv && fifo_valid;

    // Restoring division, one bit per stage; first stage yields the integer bit
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        logic [PW-1:0] sv;
        logic [PW-1:0] sub;
        logic          ge;
        logic [FB:0]   q_in;

        if (k == 0)
        begin : g_first
            assign sv   = {1'b0, e_nt};
            assign q_in = '0;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dh_reg[k]  <= e_hit;
                    dd_reg[k]  <= e_den;
                    dax_reg[k] <= e_ax;
                    day_reg[k] <= e_ay;
                    dex_reg[k] <= e_aex;
                    dey_reg[k] <= e_aey;
                    dsx_reg[k] <= e_s1x;
                    dsy_reg[k] <= e_s1y;
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_reg[k] <= fifo_valid;
                end
            end
        end
        else
        begin : g_next
            assign sv   = {dr_reg[k-1], 1'b0};
            assign q_in = dq_reg[k-1];
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dh_reg[k]  <= dh_reg[k-1];
                    dd_reg[k]  <= dd_reg[k-1];
                    dax_reg[k] <= dax_reg[k-1];
                    day_reg[k] <= day_reg[k-1];
                    dex_reg[k] <= dex_reg[k-1];
                    dey_reg[k] <= dey_reg[k-1];
                    dsx_reg[k] <= dsx_reg[k-1];
                    dsy_reg[k] <= dsy_reg[k-1];
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_reg[k] <= dv_reg[k-1];
                end
            end
        end

        // Divisor compare is against the copy of the denominator carried in with the operand
        if (k == 0)
        begin : g_cmp0
            assign ge  = sv >= {1'b0, e_den};
            assign sub = sv - {1'b0, e_den};
        end
        else
        begin : g_cmpn
            assign ge  = sv >= {1'b0, dd_reg[k-1]};
            assign sub = sv - {1'b0, dd_reg[k-1]};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dr_reg[k] <= ge ? sub[PW-2:0] : sv[PW-2:0];
                dq_reg[k] <= (q_in << 1) | (FB+1)'(ge);
            end
        end
    end

    // Offset magnitudes
    always_comb
    begin
        lsx  = dsx_reg[NS-1];
        lsy  = dsy_reg[NS-1];
        absx = lsx[D-1] ? D'(-lsx) : D'(lsx);
        absy = lsy[D-1] ? D'(-lsy) : D'(lsy);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mh_reg  <= dh_reg[NS-1];
            mnx_reg <= lsx[D-1];
            mny_reg <= lsy[D-1];
            mx_reg  <= MW'(dq_reg[NS-1]) * MW'(absx);
            my_reg  <= MW'(dq_reg[NS-1]) * MW'(absy);
            max_reg <= dax_reg[NS-1];
            may_reg <= day_reg[NS-1];
            mex_reg <= dex_reg[NS-1];
            mey_reg <= dey_reg[NS-1];
        end
    end

    // Point: start plus truncated offset, or segment A end on a miss
    always_comb
    begin
        offx = D'(mx_reg >> FB);
        offy = D'(my_reg >> FB);
        sox  = mnx_reg ? -$signed({1'b0, offx}) : $signed({1'b0, offx});
        soy  = mny_reg ? -$signed({1'b0, offy}) : $signed({1'b0, offy});
        px   = mh_reg ? (D+1)'(max_reg) + sox : (D+1)'(mex_reg);
        py   = mh_reg ? (D+1)'(may_reg) + soy : (D+1)'(mey_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            oh_reg <= mh_reg;
            ox_reg <= FIELD_W'($signed(px[CW-1:0]));
            oy_reg <= FIELD_W'($signed(py[CW-1:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            mv_reg <= dv_reg[NS-1];
            ov_reg <= mv_reg;
        end
    end

    assign seg_out.valid   = ov_reg;
    assign seg_out.hit     = oh_reg;
    assign seg_out.point_x = ox_reg;
    assign seg_out.point_y = oy_reg;

endmodule

### sim/segment_intersection_test.sv
`timescale 1ns / 1ps

module segment_intersection_test;
    import segint_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] a_start_x;
        logic [FIELD_W-1:0] a_start_y;
        logic [FIELD_W-1:0] a_end_x;
        logic [FIELD_W-1:0] a_end_y;
        logic [FIELD_W-1:0] b_start_x;
        logic [FIELD_W-1:0] b_start_y;
        logic [FIELD_W-1:0] b_end_x;
        logic [FIELD_W-1:0] b_end_y;
    } seg_pair_t;

    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] point_x;
        logic [FIELD_W-1:0] point_y;
    } crossing_t;

    // Directed row: request, and a typed-in result where known
    typedef struct packed {
        seg_pair_t pair;
        logic      typed;
        crossing_t answer;
    } pair_row_t;

    localparam int FRAC      = 16;
    localparam int ONE       = 32'h0001_0000;
    localparam int NUM_RAND  = 850;
    localparam int STALL_MAX = 5000;
    localparam int DRAIN_CYC = 40;

    logic clk;
    logic rst_n;

    seg_in_if  seg_in ();
    seg_out_if seg_out ();

    segment_intersection u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_in  (seg_in.sink),
        .seg_out (seg_out.source)
    );

    crossing_t pending_crossings[$];
    int        errors;
    int        src_idle_pct;
    int        snk_idle_pct;
    int        quiet_cycles;
    pair_row_t pair_table[12];

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Exact segment crossing at the block's widths
    function automatic crossing_t crossing_of(seg_pair_t p);
        logic signed [127:0] ax, ay, aex, aey, bx, by, bex, bey;
        logic signed [127:0] s1x, s1y, s2x, s2y, dx, dy, den, ns, nt;
        logic signed [127:0] tq, mx, my, ox, oy;
        crossing_t r;
        ax  = $signed(p.a_start_x);
        ay  = $signed(p.a_start_y);
        aex = $signed(p.a_end_x);
        aey = $signed(p.a_end_y);
        bx  = $signed(p.b_start_x);
        by  = $signed(p.b_start_y);
        bex = $signed(p.b_end_x);
        bey = $signed(p.b_end_y);
        s1x = aex - ax;
        s1y = aey - ay;
        s2x = bex - bx;
        s2y = bey - by;
        dx  = ax - bx;
        dy  = ay - by;
        den = s1x * s2y - s2x * s1y;
        ns  = s1x * dy - s1y * dx;
        nt  = s2x * dy - s2y * dx;
        if (den < 0)
        begin
            den = -den;
            ns  = -ns;
            nt  = -nt;
        end
        r.hit     = 1'b0;
        r.point_x = aex[FIELD_W-1:0];
        r.point_y = aey[FIELD_W-1:0];
        if (den != 0 && ns >= 0 && nt >= 0 && ns <= den && nt <= den)
        begin
            tq = (nt <<< FRAC) / den;
            mx = (tq * ((s1x < 0) ? -s1x : s1x)) >>> FRAC;
            my = (tq * ((s1y < 0) ? -s1y : s1y)) >>> FRAC;
            ox = (s1x < 0) ? -mx : mx;
            oy = (s1y < 0) ? -my : my;
            ox = ax + ox;
            oy = ay + oy;
            r.hit     = 1'b1;
            r.point_x = ox[FIELD_W-1:0];
            r.point_y = oy[FIELD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] near_coord();
        int v;
        v = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        return v;
    endfunction

    // Random pair, mostly shapes that reach the divider
    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int        kind;
        int        ux, uy, mx, my;
        kind = $urandom_range(0, 7);
        p.a_start_x = near_coord();
        p.a_start_y = near_coord();
        p.a_end_x   = near_coord();
        p.a_end_y   = near_coord();
        p.b_start_x = near_coord();
        p.b_start_y = near_coord();
        p.b_end_x   = near_coord();
        p.b_end_y   = near_coord();
        case (kind)
            0, 1:
            begin
                p = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            end
            4, 5, 6:
            begin
                // B crosses A at the midpoint of A
                mx = ($signed(p.a_start_x) + $signed(p.a_end_x)) / 2;
                my = ($signed(p.a_start_y) + $signed(p.a_end_y)) / 2;
                ux = int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
                uy = int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
                p.b_start_x = mx + ux;
                p.b_start_y = my + uy;
                p.b_end_x   = mx - ux;
                p.b_end_y   = my - uy;
            end
            7:
            begin
                // parallel, collinear or degenerate
                case ($urandom_range(0, 2))
                    0:
                    begin
                        p.b_end_x = p.b_start_x + (p.a_end_x - p.a_start_x);
                        p.b_end_y = p.b_start_y + (p.a_end_y - p.a_start_y);
                    end
                    1:
                    begin
                        p.b_start_x = p.a_end_x;
                        p.b_start_y = p.a_end_y;
                        p.b_end_x   = p.a_start_x;
                        p.b_end_y   = p.a_start_y;
                    end
                    default:
                    begin
                        p.b_end_x = p.b_start_x;
                        p.b_end_y = p.b_start_y;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    // Present one request and hold it until taken
    task automatic send_pair(seg_pair_t p, logic typed, crossing_t answer);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            seg_in.valid = 1'b0;
            @(negedge clk);
        end
        seg_in.valid     = 1'b1;
        seg_in.a_start_x = p.a_start_x;
        seg_in.a_start_y = p.a_start_y;
        seg_in.a_end_x   = p.a_end_x;
        seg_in.a_end_y   = p.a_end_y;
        seg_in.b_start_x = p.b_start_x;
        seg_in.b_start_y = p.b_start_y;
        seg_in.b_end_x   = p.b_end_x;
        seg_in.b_end_y   = p.b_end_y;
        do
            @(posedge clk);
        while (!seg_in.ready);
        pending_crossings.push_back(typed ? answer : crossing_of(p));
        @(negedge clk);
        seg_in.valid = 1'b0;
    endtask

    task automatic wait_results();
        while (pending_crossings.size() != 0)
            @(negedge clk);
    endtask

    // Receiver stalls
    always @(negedge clk)
    begin
        seg_out.ready = ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (seg_out.valid && seg_out.ready)
            begin
                if (pending_crossings.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result hit=%0b x=%h y=%h", $time,
                             seg_out.hit, seg_out.point_x, seg_out.point_y);
                end
                else
                begin
                    crossing_t e;
                    e = pending_crossings.pop_front();
                    if (seg_out.hit !== e.hit)
                    begin
                        errors++;
                        $display("%0t: hit expected %0b actual %0b", $time,
                                 e.hit, seg_out.hit);
                    end
                    if (seg_out.point_x !== e.point_x)
                    begin
                        errors++;
                        $display("%0t: point_x expected %h actual %h", $time,
                                 e.point_x, seg_out.point_x);
                    end
                    if (seg_out.point_y !== e.point_y)
                    begin
                        errors++;
                        $display("%0t: point_y expected %h actual %h", $time,
                                 e.point_y, seg_out.point_y);
                    end
                end
            end
            if ((seg_out.valid && seg_out.ready) || (seg_in.valid && seg_in.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int        phase;
        int        n;
        crossing_t none;
        errors       = 0;
        quiet_cycles = 0;
        none         = '0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        seg_in.valid = 1'b0;
        seg_in.a_start_x = '0;
        seg_in.a_start_y = '0;
        seg_in.a_end_x   = '0;
        seg_in.a_end_y   = '0;
        seg_in.b_start_x = '0;
        seg_in.b_start_y = '0;
        seg_in.b_end_x   = '0;
        seg_in.b_end_y   = '0;
        seg_out.ready = 1'b0;

        // zero pair: degenerate, answer is A end
        pair_table[0]  = '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b0, 0, 0}};
        // all max and all min: degenerate
        pair_table[1]  = '{'{8{32'h7fff_ffff}}, 1'b1,
                           '{1'b0, 32'h7fff_ffff, 32'h7fff_ffff}};
        pair_table[2]  = '{'{8{32'h8000_0000}}, 1'b1,
                           '{1'b0, 32'h8000_0000, 32'h8000_0000}};
        // X crossing at (1,1)
        pair_table[3]  = '{'{0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0}, 1'b1,
                           '{1'b1, ONE, ONE}};
        // parallel
        pair_table[4]  = '{'{0, 0, ONE, 0, 0, ONE, ONE, ONE}, 1'b1,
                           '{1'b0, ONE, 0}};
        // collinear, disjoint
        pair_table[5]  = '{'{0, 0, ONE, 0, 2*ONE, 0, 3*ONE, 0}, 1'b1,
                           '{1'b0, ONE, 0}};
        // touching at A end and at A start
        pair_table[6]  = '{'{0, 0, ONE, 0, ONE, 0, ONE, ONE}, 1'b1,
                           '{1'b1, ONE, 0}};
        pair_table[7]  = '{'{0, 0, ONE, 0, 0, -ONE, 0, ONE}, 1'b1,
                           '{1'b1, 0, 0}};
        // B beyond A end: miss
        pair_table[8]  = '{'{0, 0, ONE, 0, 2*ONE, -ONE, 2*ONE, ONE}, 1'b1,
                           '{1'b0, ONE, 0}};
        // full-range diagonals
        pair_table[9]  = '{'{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                             32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                             32'h7fff_ffff, 32'h8000_0000}, 1'b0, none};
        // A runs backwards
        pair_table[10] = '{'{3*ONE, 3*ONE, -ONE, -ONE, -ONE, 3*ONE, 3*ONE, -ONE},
                           1'b0, none};
        // uneven crossing, truncated t
        pair_table[11] = '{'{0, 0, 3*ONE, 7, ONE, -ONE, 32'h0000_5555, 5*ONE},
                           1'b0, none};

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 12; i++)
            send_pair(pair_table[i].pair, pair_table[i].typed, pair_table[i].answer);

        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 85 : 0;
            snk_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 8 : 0;
            for (n = 0; n < NUM_RAND / 3; n++)
                send_pair(random_pair(), 1'b0, none);
            // hold off until the pipeline has emptied
            wait_results();
        end

        wait_results();
        repeat (DRAIN_CYC) @(negedge clk);
        if (errors == 0 && pending_crossings.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
rtl/segint_pkg.sv
rtl/segint_if.sv
rtl/segint_fifo.sv
rtl/segint_front.sv
rtl/segint_back.sv
rtl/segment_intersection.sv
sim/segment_intersection_test.sv
